@@ hdl/swcd_pkg.sv @@
`timescale 1ns / 1ps

package swcd_pkg;

  localparam int unsigned NUM_WORDS = 6;
  localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS + 1);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [4:0] MEAS_BYTES = 5'd9;
  localparam logic [4:0] INFO_BYTES = 5'd18;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_INFO = 1'b1;

  // floor(x / 500) = (x * 67109) >> 25 and floor(x / 200) = (x * 83887) >> 24,
  // both exact over the whole 16-bit input range
  localparam logic [16:0] FLOW_RECIP = 17'd67109;
  localparam int unsigned FLOW_SHIFT = 25;
  localparam logic [16:0] TEMP_RECIP = 17'd83887;
  localparam int unsigned TEMP_SHIFT = 24;

  typedef struct packed {
    logic        status;
    logic [15:0] flow_raw;
    logic [7:0]  flow_scaled;
    logic [15:0] temp_raw;
    logic [8:0]  temp_scaled;
    logic [15:0] signal_flags;
    logic [31:0] product_number;
    logic [63:0] serial_number;
  } res_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] div_flow(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * {16'd0, FLOW_RECIP};
    return prod[FLOW_SHIFT +: 8];
  endfunction

  function automatic logic [8:0] div_temp(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * {16'd0, TEMP_RECIP};
    return prod[TEMP_SHIFT +: 9];
  endfunction

endpackage

@@ hdl/swcd_deframe.sv @@
`timescale 1ns / 1ps

module swcd_deframe import swcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_fire,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [1:0] PH_HI  = 2'd0;
  localparam logic [1:0] PH_LO  = 2'd1;
  localparam logic [1:0] PH_CRC = 2'd2;

  logic                  kind_r;
  logic [4:0]            pos_r, pos_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic                  fail_r, fail_nxt;
  logic [7:0]            hi_r [NUM_WORDS];
  logic [7:0]            lo_r [NUM_WORDS];

  logic [4:0]            eff_pos;
  logic [WORD_IDX_W-1:0] eff_word;
  logic [1:0]            eff_phase;
  logic [7:0]            eff_crc;
  logic                  eff_fail;
  logic [4:0]            frame_len;
  logic                  active;
  logic                  last;
  logic [15:0]           w0, w1, w2, w3, w4, w5;

  // a start byte restarts the frame before it is processed
  always_comb begin
    eff_pos   = in_frame_start ? 5'd0 : pos_r;
    eff_word  = in_frame_start ? '0 : word_r;
    eff_phase = in_frame_start ? PH_HI : phase_r;
    eff_crc   = in_frame_start ? CRC_INIT : crc_r;
    eff_fail  = in_frame_start ? 1'b0 : fail_r;
    frame_len = (kind_r == KIND_INFO) ? INFO_BYTES : MEAS_BYTES;
    active    = eff_pos < frame_len;
    last      = active && ((eff_pos + 5'd1) == frame_len);
  end

  always_comb begin
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    fail_nxt  = fail_r;
    if (in_fire) begin
      pos_nxt   = eff_pos;
      word_nxt  = eff_word;
      phase_nxt = eff_phase;
      crc_nxt   = eff_crc;
      fail_nxt  = eff_fail;
      if (active) begin
        pos_nxt = eff_pos + 5'd1;
        case (eff_phase)
          PH_HI, PH_LO: begin
            crc_nxt   = crc8_fold(eff_crc, in_rx_byte);
            phase_nxt = eff_phase + 2'd1;
          end
          PH_CRC: begin
            fail_nxt  = eff_fail | (eff_crc != in_rx_byte);
            crc_nxt   = CRC_INIT;
            phase_nxt = PH_HI;
            word_nxt  = eff_word + WORD_IDX_W'(1);
          end
          default: begin
            phase_nxt = PH_HI;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_MEAS;
      pos_r   <= '0;
      word_r  <= '0;
      phase_r <= PH_HI;
      crc_r   <= CRC_INIT;
      fail_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        kind_r <= cfg_wdata;
      end
      pos_r   <= pos_nxt;
      word_r  <= word_nxt;
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && active && (eff_phase == PH_HI)) begin
      hi_r[eff_word] <= in_rx_byte;
    end
    if (in_fire && active && (eff_phase == PH_LO)) begin
      lo_r[eff_word] <= in_rx_byte;
    end
  end

  // every data byte of the frame is stored by the time its last (CRC) byte arrives
  assign w0 = {hi_r[0], lo_r[0]};
  assign w1 = {hi_r[1], lo_r[1]};
  assign w2 = {hi_r[2], lo_r[2]};
  assign w3 = {hi_r[3], lo_r[3]};
  assign w4 = {hi_r[4], lo_r[4]};
  assign w5 = {hi_r[5], lo_r[5]};

  assign res_valid = in_fire && last;

  always_comb begin
    res        = '0;
    res.status = eff_fail | (eff_crc != in_rx_byte);
    if (kind_r == KIND_MEAS) begin
      res.flow_raw     = w0;
      res.flow_scaled  = div_flow(w0);
      res.temp_raw     = w1;
      res.temp_scaled  = div_temp(w1);
      res.signal_flags = w2;
    end else begin
      res.product_number = {w0, w1};
      res.serial_number  = {w2, w3, w4, w5};
    end
  end

endmodule

@@ hdl/swcd_out_buf.sv @@
`timescale 1ns / 1ps

module swcd_out_buf import swcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  res_t res,
  output logic space_ok,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic main_valid_r;
  logic skid_valid_r;
  res_t main_r;
  res_t skid_r;
  logic take;

  assign take      = main_valid_r && out_ready;
  assign space_ok  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no new result can arrive while the skid slot is full
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (main_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (res_valid) begin
      if (main_valid_r && !take) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

endmodule

@@ hdl/sensor_word_crc_deframer_top.sv @@
`timescale 1ns / 1ps

// Sensor reply deframer. Bytes of a reply arrive one per transfer as a run of
// [MSB][LSB][CRC] triplets; each triplet is checked with CRC-8 (poly 0x31,
// init 0xFF, restarted per word). cfg_wdata (with cfg_we) selects a measurement frame
// (0: 3 words, 9 bytes) or an info frame (1: 6 words, 18 bytes); write it only
// while the block is idle. in_frame_start marks the first byte of a frame and
// drops any frame in progress. One result transfer follows the last byte of a
// frame, carrying status (1 if any word CRC mismatched) and either the
// measurement fields (flow, flow/500, temperature, temperature/200, flags) or
// the info fields (32-bit product number, 64-bit serial number); the fields
// of the other kind read zero. Bytes past the end of a frame are dropped until
// the next frame start. Throughput is one byte per clock while in_ready is
// high: CRC folding and word capture finish in the accepting cycle, and the
// result is registered as its last byte transfers. A two-slot output buffer
// lets input continue while a result waits; in_ready falls only when both
// slots hold results, which takes a stalled output across two whole frames.

module sensor_word_crc_deframer_top import swcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [15:0] out_flow_raw,
  output logic [7:0]  out_flow_scaled,
  output logic [15:0] out_temp_raw,
  output logic [8:0]  out_temp_scaled,
  output logic [15:0] out_signal_flags,
  output logic [31:0] out_product_number,
  output logic [63:0] out_serial_number
);

  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_res;

  // accept a byte whenever the output buffer has a free slot
  assign in_fire = in_valid && in_ready;

  swcd_deframe u_deframe (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_fire        (in_fire),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .res_valid      (res_valid),
    .res            (res)
  );

  // hold finished results here so the byte stream keeps moving
  swcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_flow_raw       = out_res.flow_raw;
  assign out_flow_scaled    = out_res.flow_scaled;
  assign out_temp_raw       = out_res.temp_raw;
  assign out_temp_scaled    = out_res.temp_scaled;
  assign out_signal_flags   = out_res.signal_flags;
  assign out_product_number = out_res.product_number;
  assign out_serial_number  = out_res.serial_number;

endmodule

@@ hdl/swcd_checker.sv @@
`timescale 1ns / 1ps

module swcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [15:0] out_flow_raw,
  input logic [7:0]  out_flow_scaled,
  input logic [15:0] out_temp_raw,
  input logic [8:0]  out_temp_scaled,
  input logic [15:0] out_signal_flags,
  input logic [31:0] out_product_number,
  input logic [63:0] out_serial_number
);

  logic [31:0] flow_lo, temp_lo;

  assign flow_lo = {24'd0, out_flow_scaled} * 32'd500;
  assign temp_lo = {23'd0, out_temp_scaled} * 32'd200;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_flow_raw)
      && $stable(out_product_number) && $stable(out_serial_number))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_product_number == 32'd0 && out_serial_number == 64'd0)
      || (out_flow_raw == 16'd0 && out_flow_scaled == 8'd0 && out_temp_raw == 16'd0
          && out_temp_scaled == 9'd0 && out_signal_flags == 16'd0))
    else $error("result mixes measurement and info fields");

  a_scaling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({16'd0, out_flow_raw} >= flow_lo)
      && ({16'd0, out_flow_raw} < flow_lo + 32'd500)
      && ({16'd0, out_temp_raw} >= temp_lo)
      && ({16'd0, out_temp_raw} < temp_lo + 32'd200))
    else $error("scaled value does not match raw value");

endmodule

bind sensor_word_crc_deframer_top swcd_checker u_swcd_checker (.*);

@@ bench/sensor_word_crc_deframer_top_tb.sv @@
`timescale 1ns / 1ps

module sensor_word_crc_deframer_top_tb;
  import swcd_pkg::*;

  // Directed rows either move one byte or rewrite the frame kind register.
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [7:0] data;
    logic start;
    bit has_res;
    res_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [15:0] out_flow_raw;
  logic [7:0]  out_flow_scaled;
  logic [15:0] out_temp_raw;
  logic [8:0]  out_temp_scaled;
  logic [15:0] out_signal_flags;
  logic [31:0] out_product_number;
  logic [63:0] out_serial_number;

  // Typed-in expectation that travels with the byte on the input channel.
  // Drive it with nonblocking assignments alongside in_valid so the byte
  // monitor sees the value that belongs to the transfer at that edge.
  bit   row_has_res = 1'b0;
  res_t row_res = '0;

  // Mirror of the deframer state, advanced on every input transfer.
  logic        model_kind = KIND_MEAS;
  logic [7:0]  model_crc = CRC_INIT;
  logic [4:0]  model_pos = 5'd0;
  logic        model_failed = 1'b0;
  logic [15:0] model_words [NUM_WORDS];

  res_t        due_reports [$];
  stim_row_t   script [$];
  int          fault_count = 0;
  int          bytes_taken = 0;
  bit          steady = 1'b0;
  logic        stim_kind = KIND_MEAS;

  sensor_word_crc_deframer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_flow_raw       (out_flow_raw),
    .out_flow_scaled    (out_flow_scaled),
    .out_temp_raw       (out_temp_raw),
    .out_temp_scaled    (out_temp_scaled),
    .out_signal_flags   (out_signal_flags),
    .out_product_number (out_product_number),
    .out_serial_number  (out_serial_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("sensor_word_crc_deframer_top_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One byte through CRC-8, poly 0x31, MSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the mirrored state by one byte; return 1 with the frame report
  // when this byte completes a frame.
  function automatic bit deframe_byte(input logic [7:0] b, input logic start,
                                      output res_t rep);
    logic [4:0] len;
    int unsigned widx;
    rep = '0;
    len = (model_kind == KIND_INFO) ? INFO_BYTES : MEAS_BYTES;
    if (start) begin
      model_pos = 5'd0;
      model_crc = CRC_INIT;
      model_failed = 1'b0;
    end
    // Drop bytes past the end of the frame until the next frame start.
    if (model_pos >= len) return 1'b0;
    widx = 32'(model_pos) / 32'd3;
    case (model_pos % 5'd3)
      5'd0: begin
        model_words[widx] = {b, 8'h00};
        model_crc = crc8_next(model_crc, b);
      end
      5'd1: begin
        model_words[widx][7:0] = b;
        model_crc = crc8_next(model_crc, b);
      end
      default: begin
        if (model_crc != b) model_failed = 1'b1;
        model_crc = CRC_INIT;
      end
    endcase
    model_pos = model_pos + 5'd1;
    if (model_pos != len) return 1'b0;
    rep.status = model_failed;
    if (model_kind == KIND_MEAS) begin
      rep.flow_raw     = model_words[0];
      rep.flow_scaled  = 8'(model_words[0] / 16'd500);
      rep.temp_raw     = model_words[1];
      rep.temp_scaled  = 9'(model_words[1] / 16'd200);
      rep.signal_flags = model_words[2];
    end else begin
      rep.product_number = {model_words[0], model_words[1]};
      rep.serial_number  = {model_words[2], model_words[3], model_words[4], model_words[5]};
    end
    return 1'b1;
  endfunction

  // Track register writes and input transfers at the edge where they land.
  always @(posedge clk) begin : byte_monitor
    res_t rep;
    bit got;
    if (rst_n) begin
      if (cfg_we) model_kind = cfg_wdata;
      if (in_valid && in_ready) begin
        bytes_taken++;
        got = deframe_byte(in_rx_byte, in_frame_start, rep);
        // A typed-in expectation replaces the predicted one for its row.
        if (row_has_res) due_reports.push_back(row_res);
        else if (got) due_reports.push_back(rep);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : report_monitor
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t ns: report with none expected, expected nothing, actual status %0h",
                 $time, out_status);
        fault_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("flow_raw", 64'(want.flow_raw), 64'(out_flow_raw));
        check_field("flow_scaled", 64'(want.flow_scaled), 64'(out_flow_scaled));
        check_field("temp_raw", 64'(want.temp_raw), 64'(out_temp_raw));
        check_field("temp_scaled", 64'(want.temp_scaled), 64'(out_temp_scaled));
        check_field("signal_flags", 64'(want.signal_flags), 64'(out_signal_flags));
        check_field("product_number", 64'(want.product_number),
                    64'(out_product_number));
        check_field("serial_number", want.serial_number, out_serial_number);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, sometimes a short one, rarely a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: stall at random, never raise and drop in one step.
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Offer one byte and hold it until the transfer happens.
  task automatic push_byte(input logic [7:0] data, input logic start,
                           input bit has_res, input res_t res);
    int unsigned n;
    n = pick_gap();
    if (n > 0) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= data;
    in_frame_start <= start;
    row_has_res    <= has_res;
    row_res        <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain every expected report, then let the output pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kind(input logic k);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stim_kind = k;
  endtask

  task automatic send_word(input logic [15:0] w, input logic start, input bit bad_crc);
    logic [7:0] crc;
    crc = word_crc(w);
    if (bad_crc) crc ^= 8'h01 << $urandom_range(0, 7);
    push_byte(w[15:8], start, 1'b0, '0);
    push_byte(w[7:0], 1'b0, 1'b0, '0);
    push_byte(crc, 1'b0, 1'b0, '0);
  endtask

  // Bias words toward the extremes and the divider boundaries.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 131) * 500 - $urandom_range(0, 1));
      3: return 16'($urandom_range(0, 327) * 200 + $urandom_range(0, 1));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Well-formed frame of the current kind; corrupt one word's CRC on request.
  task automatic send_frame(input logic start, input bit bad);
    int nwords;
    int bad_word;
    nwords = (stim_kind == KIND_INFO) ? 6 : 3;
    bad_word = bad ? $urandom_range(0, nwords - 1) : -1;
    for (int i = 0; i < nwords; i++) begin
      send_word(pick_word(), (i == 0) ? start : 1'b0, i == bad_word);
    end
  endtask

  // Frame that stops short; the next frame start drops it.
  task automatic send_stub();
    int n;
    n = $urandom_range(1, (stim_kind == KIND_INFO) ? 17 : 8);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom), i == 0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------

  task automatic add_row(input row_kind_t kind, input logic [7:0] data, input logic start);
    stim_row_t row;
    row.kind = kind;
    row.data = data;
    row.start = start;
    row.has_res = 1'b0;
    row.res = '0;
    script.push_back(row);
  endtask

  task automatic add_word_rows(input logic [15:0] w, input logic start, input bit bad_crc);
    logic [7:0] crc;
    crc = word_crc(w) ^ (bad_crc ? 8'h01 : 8'h00);
    add_row(ROW_BYTE, w[15:8], start);
    add_row(ROW_BYTE, w[7:0], 1'b0);
    add_row(ROW_BYTE, crc, 1'b0);
  endtask

  task automatic expect_last(input res_t r);
    script[script.size() - 1].has_res = 1'b1;
    script[script.size() - 1].res = r;
  endtask

  task automatic build_script();
    res_t r;
    // Right after reset, with no frame start: the bytes still open a frame.
    // Full-scale flow and temperature give the largest scaled values.
    add_word_rows(16'hFFFF, 1'b0, 1'b0);
    add_word_rows(16'hFFFF, 1'b0, 1'b0);
    add_word_rows(16'h0000, 1'b0, 1'b0);
    r = '0;
    r.flow_raw = 16'hFFFF;
    r.flow_scaled = 8'd131;
    r.temp_raw = 16'hFFFF;
    r.temp_scaled = 9'd327;
    expect_last(r);
    // Byte past the end of the frame: dropped, no report.
    add_row(ROW_BYTE, 8'hA5, 1'b0);
    // Two bytes of a frame, then a new frame start abandons them.
    add_row(ROW_BYTE, 8'h12, 1'b1);
    add_row(ROW_BYTE, 8'h34, 1'b0);
    // Bad CRC on the first word: report still comes, flagged.
    add_word_rows(16'h0000, 1'b1, 1'b1);
    add_word_rows(16'h0000, 1'b0, 1'b0);
    add_word_rows(16'hFFFF, 1'b0, 1'b0);
    r = '0;
    r.status = 1'b1;
    r.signal_flags = 16'hFFFF;
    expect_last(r);
    // Info frame of all ones.
    add_row(ROW_CFG, 8'(KIND_INFO), 1'b0);
    for (int i = 0; i < 6; i++) add_word_rows(16'hFFFF, i == 0, 1'b0);
    r = '0;
    r.product_number = 32'hFFFF_FFFF;
    r.serial_number = 64'hFFFF_FFFF_FFFF_FFFF;
    expect_last(r);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned pick;
    int phase;
    for (int i = 0; i < NUM_WORDS; i++) model_words[i] = 16'h0000;
    build_script();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_kind(script[i].data[0]);
      else push_byte(script[i].data, script[i].start, script[i].has_res, script[i].res);
    end

    // Random phases: each rewrites the kind, then mixes mostly clean frames
    // with stubs, noise and frames that never see a start marker.
    phase = 0;
    while (bytes_taken < 800) begin
      write_kind((phase == 0) ? KIND_MEAS : logic'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 14)) begin
        if (bytes_taken >= 800) break;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame(1'b1, $urandom_range(0, 5) == 0);
          // Trailing bytes past the frame end.
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0, '0);
          end
        end else if (pick < 85) begin
          send_stub();
        end else if (pick < 93) begin
          repeat ($urandom_range(1, 12)) begin
            push_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
          end
        end else begin
          send_frame(1'b0, $urandom_range(0, 3) == 0);
        end
      end
      // Leave a frame half done so the next kind change lands mid-frame.
      if ($urandom_range(0, 2) == 0) send_stub();
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    if (fault_count == 0) begin
      $display("sensor_word_crc_deframer_top_tb OK");
    end else begin
      $display("sensor_word_crc_deframer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/swcd_pkg.sv
hdl/swcd_deframe.sv
hdl/swcd_out_buf.sv
hdl/sensor_word_crc_deframer_top.sv
hdl/swcd_checker.sv
bench/sensor_word_crc_deframer_top_tb.sv
